### src/sgr_pkg.sv
// types, constants and font table shared by the glyph row renderer
package sgr_pkg;

  // field widths
  localparam int CODE_W     = 8;
  localparam int COORD_W    = 12;
  localparam int ROW_Y_W    = 13;
  localparam int SCALE_W    = 4;
  localparam int ADDR_W     = 32;
  localparam int PITCH_W    = 14;
  localparam int COLOR_W    = 32;
  localparam int MASK_W     = 40;
  localparam int GLYPH_W    = 6;
  localparam int GROW_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // font geometry
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_COUNT = 36;
  localparam int DIGIT_BASE  = 26;

  // character codes that draw
  localparam logic [CODE_W-1:0] CODE_A    = 8'h41;
  localparam logic [CODE_W-1:0] CODE_Z    = 8'h5A;
  localparam logic [CODE_W-1:0] CODE_ZERO = 8'h30;
  localparam logic [CODE_W-1:0] CODE_NINE = 8'h39;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_WORDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR       = 2'd2;

  // register reset values
  localparam logic [ADDR_W-1:0]  RST_FRAME_BASE  = 32'h0000_0000;
  localparam logic [PITCH_W-1:0] RST_PITCH_WORDS = 14'd1024;
  localparam logic [COLOR_W-1:0] RST_COLOR       = 32'h00FF_FFFF;

  // command queue depth
  localparam int CMD_DEPTH = 2;

  typedef struct packed {
    logic [CODE_W-1:0]  char_code;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [SCALE_W-1:0] scale;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] row_x;
    logic [ROW_Y_W-1:0] row_y;
    logic [ADDR_W-1:0]  word_address;
    logic [MASK_W-1:0]  pixel_mask;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_row;
  } out_item_t;

  // classified glyph command, scale already saturated and nonzero
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [SCALE_W-1:0] scale;
  } glyph_cmd_t;

  typedef struct packed {
    logic       push;
    glyph_cmd_t cmd;
  } cmd_push_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_ADDR,
    BK_ROWS
  } back_state_t;

  // 5x7 font, row 0 on top, column 0 in bit 4
  localparam logic [0:GLYPH_ROWS-1][GLYPH_COLS-1:0] FONT_ROM [GLYPH_COUNT] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},  // A
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},  // B
    '{5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F},  // C
    '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},  // D
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},  // E
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},  // F
    '{5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},  // G
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},  // H
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},  // I
    '{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},  // J
    '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},  // K
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},  // L
    '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},  // M
    '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},  // N
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},  // O
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},  // P
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},  // Q
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},  // R
    '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},  // S
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},  // T
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},  // U
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},  // V
    '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A},  // W
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},  // X
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},  // Y
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},  // Z
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},  // 0
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},  // 1
    '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},  // 2
    '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},  // 3
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},  // 4
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},  // 5
    '{5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},  // 6
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},  // 7
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},  // 8
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E}   // 9
  };

  // repeat each font column k times, column 0 in the low bits
  function automatic logic [MASK_W-1:0] widen_row(input logic [GLYPH_COLS-1:0] bits,
                                                   input logic [SCALE_W-1:0] k);
    logic [MASK_W-1:0] m;
    logic [6:0]        lo;
    logic [6:0]        hi;
    m = '0;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      lo = 7'(c) * 7'(k);
      hi = lo + 7'(k);
      for (int i = 0; i < MASK_W; i++) begin
        if (bits[GLYPH_COLS-1-c] && (7'(i) >= lo) && (7'(i) < hi)) begin
          m[i] = 1'b1;
        end
      end
    end
    return m;
  endfunction

endpackage

### src/scaled_glyph_row_renderer.sv
// top level of the scaled glyph row renderer: config registers and unit hookup
//
// Each input transaction names a character, a cell position and a scale. Codes
// A-Z and 0-9 are drawn from a 5x7 font; every other code, and a scale of zero,
// is accepted and consumed with no result. Scales above MAX_SCALE are clamped.
// A drawable glyph produces 7*scale row transactions, top to bottom, each with
// its row y, line word address (frame_base + y*pitch_words + x, wrapping at 32
// bits), a 40-bit pixel mask with each font column repeated scale times (font
// column 0 in the low bits; columns past bit 39 are dropped) and the color.
// The row sequencer forms the first line address in BK_MUL (the y*pitch multiply)
// and BK_ADDR (the add) and then emits one row per cycle while the output is not
// stalled. A two-entry command queue lets the input side keep accepting while
// rows are produced. Configuration writes are always accepted, as cfg_ready is
// tied high, and should be issued only while no glyph is in flight.
module scaled_glyph_row_renderer #(
  parameter int MAX_SCALE = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sgr_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sgr_pkg::out_item_t                   out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sgr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sgr_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import sgr_pkg::*;

  logic [ADDR_W-1:0]  frame_base_r, frame_base_nxt;
  logic [PITCH_W-1:0] pitch_words_r, pitch_words_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  cmd_push_t          q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  glyph_cmd_t         q_data;

  assign cfg_ready = 1'b1;

  // register write decode
  always_comb begin
    frame_base_nxt  = frame_base_r;
    pitch_words_nxt = pitch_words_r;
    color_nxt       = color_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_BASE:  frame_base_nxt  = ADDR_W'(cfg_data);
        REG_PITCH_WORDS: pitch_words_nxt = cfg_data[PITCH_W-1:0];
        REG_COLOR:       color_nxt       = COLOR_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r  <= RST_FRAME_BASE;
      pitch_words_r <= RST_PITCH_WORDS;
      color_r       <= RST_COLOR;
    end else begin
      frame_base_r  <= frame_base_nxt;
      pitch_words_r <= pitch_words_nxt;
      color_r       <= color_nxt;
    end
  end

  // input decode
  sgr_front #(
    .MAX_SCALE(MAX_SCALE)
  ) u_front (
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push)
  );

  // command queue
  sgr_cmd_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_valid(q_valid),
    .q_data (q_data)
  );

  // row sequencer
  sgr_back #(
    .MAX_SCALE(MAX_SCALE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .frame_base (frame_base_r),
    .pitch_words(pitch_words_r),
    .color      (color_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### src/sgr_front.sv
// front end: accepts input transactions, decodes the glyph and saturates the scale
module sgr_front #(
  parameter int MAX_SCALE = 8
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  sgr_pkg::in_item_t  in_data,
  input  logic               q_full,
  output sgr_pkg::cmd_push_t q_push
);
  import sgr_pkg::*;

  localparam logic [SCALE_W-1:0] SCALE_MAX = SCALE_W'(MAX_SCALE);

  logic               is_letter;
  logic               is_digit;
  logic [GLYPH_W-1:0] glyph;
  logic [SCALE_W-1:0] scale_sat;

  // take a transaction whenever the queue has room; undrawable ones are dropped
  assign in_ready = !q_full;

  // glyph decode
  always_comb begin
    is_letter = (in_data.char_code >= CODE_A) && (in_data.char_code <= CODE_Z);
    is_digit  = (in_data.char_code >= CODE_ZERO) && (in_data.char_code <= CODE_NINE);
    if (is_letter) begin
      glyph = GLYPH_W'(in_data.char_code - CODE_A);
    end else begin
      glyph = GLYPH_W'(DIGIT_BASE) + GLYPH_W'(in_data.char_code - CODE_ZERO);
    end
    scale_sat = (in_data.scale > SCALE_MAX) ? SCALE_MAX : in_data.scale;
  end

  // push only glyphs that produce rows
  always_comb begin
    q_push.push        = in_valid && in_ready && (is_letter || is_digit) &&
                         (in_data.scale != '0);
    q_push.cmd.glyph   = glyph;
    q_push.cmd.start_x = in_data.start_x;
    q_push.cmd.start_y = in_data.start_y;
    q_push.cmd.scale   = scale_sat;
  end

endmodule

### src/sgr_cmd_fifo.sv
// short command queue between front end and row sequencer
module sgr_cmd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  sgr_pkg::cmd_push_t  q_push,
  output logic                q_full,
  input  logic                q_pop,
  output logic                q_valid,
  output sgr_pkg::glyph_cmd_t q_data
);
  import sgr_pkg::*;

  localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_DEPTH);

  glyph_cmd_t       mem_r [CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign q_full  = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign do_push = q_push.push && !q_full;
  assign do_pop  = q_pop && q_valid;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.cmd;
    end
  end

  // front end must never push into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push.push)
    else $error("command pushed into full queue");

endmodule

### src/sgr_back.sv
// row sequencer: computes the line address and emits one scaled row per cycle while the output is not stalled
module sgr_back #(
  parameter int MAX_SCALE = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  sgr_pkg::glyph_cmd_t           q_data,
  output logic                          q_pop,
  input  logic [sgr_pkg::ADDR_W-1:0]    frame_base,
  input  logic [sgr_pkg::PITCH_W-1:0]   pitch_words,
  input  logic [sgr_pkg::COLOR_W-1:0]   color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sgr_pkg::out_item_t            out_data
);
  import sgr_pkg::*;

  localparam int REP_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
  localparam int PROD_W = COORD_W + PITCH_W;

  back_state_t       state_r, state_nxt;
  glyph_cmd_t        cmd_r, cmd_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ROW_Y_W-1:0] y_r, y_nxt;
  logic [GROW_W-1:0] g_r, g_nxt;
  logic [REP_W-1:0]  rep_r, rep_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic              out_free;
  logic              emit;
  logic              rep_last;
  logic              row_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign rep_last  = (SCALE_W'(rep_r) == cmd_r.scale - 1'b1);
  assign row_last  = (g_r == GROW_W'(GLYPH_ROWS - 1)) && rep_last;

  // next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    prod_nxt      = prod_r;
    addr_nxt      = addr_r;
    y_nxt         = y_r;
    g_nxt         = g_r;
    rep_nxt       = rep_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    emit          = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_data;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL: begin
        prod_nxt  = PROD_W'(cmd_r.start_y) * PROD_W'(pitch_words);
        state_nxt = BK_ADDR;
      end
      BK_ADDR: begin
        addr_nxt  = frame_base + ADDR_W'(prod_r) + ADDR_W'(cmd_r.start_x);
        y_nxt     = ROW_Y_W'(cmd_r.start_y);
        g_nxt     = '0;
        rep_nxt   = '0;
        state_nxt = BK_ROWS;
      end
      BK_ROWS: begin
        if (out_free) begin
          emit                      = 1'b1;
          out_valid_nxt             = 1'b1;
          out_data_nxt.row_x        = cmd_r.start_x;
          out_data_nxt.row_y        = y_r;
          out_data_nxt.word_address = addr_r;
          out_data_nxt.pixel_mask   = widen_row(FONT_ROM[cmd_r.glyph][g_r], cmd_r.scale);
          out_data_nxt.pixel_color  = color;
          out_data_nxt.last_row     = row_last;
          y_nxt                     = y_r + 1'b1;
          addr_nxt                  = addr_r + ADDR_W'(pitch_words);
          if (rep_last) begin
            rep_nxt = '0;
            g_nxt   = g_r + 1'b1;
          end else begin
            rep_nxt = rep_r + 1'b1;
          end
          if (row_last) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    prod_r     <= prod_nxt;
    addr_r     <= addr_nxt;
    y_r        <= y_nxt;
    g_r        <= g_nxt;
    rep_r      <= rep_nxt;
    out_data_r <= out_data_nxt;
  end

  // a busy sequencer always holds a saturated nonzero scale
  a_scale_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> ((cmd_r.scale != '0) &&
                              (cmd_r.scale <= SCALE_W'(MAX_SCALE))))
    else $error("sequencer busy with bad scale");

  // row counters stay inside the glyph
  a_counters_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_ROWS) |-> ((g_r <= GROW_W'(GLYPH_ROWS - 1)) &&
                              (SCALE_W'(rep_r) < cmd_r.scale)))
    else $error("row counter out of range");

  // the final row ends the glyph
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && row_last) |=> (state_r == BK_IDLE))
    else $error("sequencer kept running after last row");

endmodule

### sim/scaled_glyph_row_renderer_test.sv
// self-checking testbench for the scaled glyph row renderer
`timescale 1ns / 100ps

module scaled_glyph_row_renderer_test;
  import sgr_pkg::*;

  localparam int SCALE_CAP     = 8;
  localparam int IDLE_PCT      = 35;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_PRINT     = 40;
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 38;
  localparam int HOLD_PHASE    = 1;
  localparam int STEADY_PHASE  = 2;

  // index past the last register, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  // expected row transactions, built from the glyph and the register copy
  class glyph_row_ledger;
    logic [ADDR_W-1:0]  frame_base;
    logic [PITCH_W-1:0] pitch_words;
    logic [COLOR_W-1:0] color;
    out_item_t          rows_owed[$];
    int                 errors;

    function new();
      frame_base  = 32'h0000_0000;
      pitch_words = 14'd1024;
      color       = 32'h00FF_FFFF;
      errors      = 0;
    endfunction

    function int pending();
      return rows_owed.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_FRAME_BASE:  frame_base  = data;
        REG_PITCH_WORDS: pitch_words = data[PITCH_W-1:0];
        REG_COLOR:       color       = data;
        default: ;
      endcase
    endfunction

    // 5x7 font, seven rows of five bits, top row first, column 0 in the msb
    function logic [34:0] font_rows(int unsigned g);
      case (g)
        0:  return {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
        1:  return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
        2:  return {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
        3:  return {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
        4:  return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
        5:  return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
        6:  return {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
        7:  return {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
        8:  return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
        9:  return {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
        10: return {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
        11: return {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
        12: return {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
        13: return {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
        14: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
        15: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
        16: return {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
        17: return {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
        18: return {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
        19: return {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
        20: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
        21: return {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
        22: return {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
        23: return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
        24: return {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
        25: return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
        26: return {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
        27: return {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
        28: return {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
        29: return {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
        30: return {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
        31: return {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
        32: return {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
        33: return {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
        34: return {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
        default: return {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
      endcase
    endfunction

    // queue every scaled row that one accepted glyph transaction should produce
    function void draw_glyph(in_item_t it);
      int unsigned glyph;
      int unsigned k;
      int unsigned y;
      int unsigned addr;
      int unsigned n;
      logic [34:0]           rows;
      logic [GLYPH_COLS-1:0] bits;
      logic [MASK_W-1:0]     mask;
      out_item_t             row;
      if (it.char_code >= CODE_A && it.char_code <= CODE_Z) begin
        glyph = it.char_code - CODE_A;
      end else if (it.char_code >= CODE_ZERO && it.char_code <= CODE_NINE) begin
        glyph = DIGIT_BASE + (it.char_code - CODE_ZERO);
      end else begin
        return;
      end
      k = it.scale;
      if (k == 0) return;
      if (k > SCALE_CAP) k = SCALE_CAP;
      rows = font_rows(glyph);
      n = 0;
      for (int g = 0; g < GLYPH_ROWS; g++) begin
        bits = rows[34 - GLYPH_COLS * g -: GLYPH_COLS];
        // each font column repeated k times, column 0 lowest
        mask = '0;
        for (int c = 0; c < GLYPH_COLS; c++) begin
          if (bits[GLYPH_COLS - 1 - c]) begin
            for (int r = 0; r < k; r++) mask[c * k + r] = 1'b1;
          end
        end
        for (int rep = 0; rep < k; rep++) begin
          y    = it.start_y + g * k + rep;
          addr = frame_base + y * pitch_words + it.start_x;
          row.row_x        = it.start_x;
          row.row_y        = ROW_Y_W'(y);
          row.word_address = addr;
          row.pixel_mask   = mask;
          row.pixel_color  = color;
          row.last_row     = (n + 1 == GLYPH_ROWS * k);
          rows_owed.push_back(row);
          n++;
        end
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINT) $display("row check failed: %s", what);
    endtask

    task cmp_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // compare one accepted row against the oldest owed row
    task retire_row(out_item_t got);
      out_item_t want;
      if (rows_owed.size() == 0) begin
        report($sformatf("unexpected row x=%0h y=%0h", got.row_x, got.row_y));
        return;
      end
      want = rows_owed.pop_front();
      cmp_field("row_x", got.row_x, want.row_x);
      cmp_field("row_y", got.row_y, want.row_y);
      cmp_field("word_address", got.word_address, want.word_address);
      cmp_field("pixel_mask", got.pixel_mask, want.pixel_mask);
      cmp_field("pixel_color", got.pixel_color, want.pixel_color);
      cmp_field("last_row", got.last_row, want.last_row);
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  glyph_row_ledger ledger;

  scaled_glyph_row_renderer #(
    .MAX_SCALE(SCALE_CAP)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: check each row transaction, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.retire_row(out_data);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rx_steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic in_item_t make_glyph(logic [CODE_W-1:0] code, logic [COORD_W-1:0] x,
                                          logic [COORD_W-1:0] y, logic [SCALE_W-1:0] s);
    in_item_t it;
    it.char_code = code;
    it.start_x   = x;
    it.start_y   = y;
    it.scale     = s;
    return it;
  endfunction

  // mostly drawable glyphs at small scales, some raw noise
  function automatic in_item_t rand_glyph();
    in_item_t it;
    int       r;
    it.start_x = COORD_W'($urandom_range(4095));
    it.start_y = COORD_W'($urandom_range(4095));
    if ($urandom_range(99) < 15) begin
      it.char_code = CODE_W'($urandom_range(255));
      it.scale     = SCALE_W'($urandom_range(15));
    end else begin
      if ($urandom_range(1)) it.char_code = CODE_W'(CODE_A + $urandom_range(25));
      else                   it.char_code = CODE_W'(CODE_ZERO + $urandom_range(9));
      r = $urandom_range(99);
      if (r < 60)      it.scale = SCALE_W'($urandom_range(2, 1));
      else if (r < 85) it.scale = SCALE_W'($urandom_range(5, 3));
      else if (r < 95) it.scale = SCALE_W'($urandom_range(8, 6));
      else             it.scale = SCALE_W'($urandom_range(15, 9));
    end
    return it;
  endfunction

  // offer one glyph transaction, with random idle cycles ahead of it
  task automatic send_glyph(in_item_t it);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    ledger.draw_glyph(it);
  endtask

  // drain the block, then write the registers, optionally poking the unused index
  task automatic set_regs(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] pitch_bits,
                          logic [CFG_DATA_W-1:0] tint, bit poke_unused);
    logic [CFG_IDX_W-1:0]  idx [4];
    logic [CFG_DATA_W-1:0] val [4];
    int                    first;
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    idx   = '{REG_NONE, REG_FRAME_BASE, REG_PITCH_WORDS, REG_COLOR};
    val   = '{$urandom(), base, pitch_bits, tint};
    first = poke_unused ? 0 : 1;
    for (int i = first; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      ledger.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : main
    logic [CFG_DATA_W-1:0] base;
    logic [CFG_DATA_W-1:0] pitch_bits;
    ledger = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values, field extremes and codes around the drawable ranges
    send_glyph(make_glyph(CODE_A, '0, '0, 4'd1));
    send_glyph(make_glyph(CODE_Z, '1, '1, 4'd8));
    send_glyph(make_glyph(CODE_ZERO, 12'd100, 12'd200, 4'd2));
    send_glyph(make_glyph(CODE_NINE, '1, '0, 4'd15));
    send_glyph(make_glyph(CODE_A + 8'd22, '0, '1, 4'd9));
    send_glyph(make_glyph(CODE_A + 8'd12, 12'd5, 12'd5, 4'd0));
    send_glyph(make_glyph(CODE_A - 8'd1, 12'd7, 12'd9, 4'd3));
    send_glyph(make_glyph(CODE_Z + 8'd1, 12'd7, 12'd9, 4'd3));
    send_glyph(make_glyph(CODE_ZERO - 8'd1, 12'd1, 12'd1, 4'd1));
    send_glyph(make_glyph(CODE_NINE + 8'd1, 12'd1, 12'd1, 4'd1));
    send_glyph(make_glyph('0, 12'd3, 12'd3, 4'd2));
    send_glyph(make_glyph('1, 12'd3, 12'd3, 4'd2));
    send_glyph(make_glyph(CODE_A + 8'd16, 12'd2048, 12'd1, 4'd4));

    // register extremes, address wrap
    set_regs(32'hFFFF_FFFF, 32'd8192, 32'h0000_0000, 1'b1);
    send_glyph(make_glyph(CODE_Z, '1, '1, 4'd8));
    send_glyph(make_glyph(CODE_A, '0, '0, 4'd1));
    send_glyph(make_glyph(CODE_ZERO + 8'd8, 12'd1234, 12'd2345, 4'd5));

    // pitch of zero reached through the upper data bits being dropped
    set_regs(32'h8000_0001, 32'hFFFF_C000, 32'hFFFF_FFFF, 1'b1);
    send_glyph(make_glyph(CODE_A + 8'd7, 12'd10, 12'd20, 4'd3));
    send_glyph(make_glyph(CODE_ZERO + 8'd5, '1, '1, 4'd8));

    // widest pitch the field holds
    set_regs(32'h0000_1000, 32'h0000_3FFF, 32'h1234_5678, 1'b0);
    send_glyph(make_glyph(CODE_A + 8'd9, 12'd4000, 12'd4090, 4'd6));
    send_glyph(make_glyph(CODE_ZERO + 8'd4, 12'd0, 12'd4095, 4'd7));

    // random phases: one with a long receiver hold-off, one with no idling
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(3))
        0:       base = 32'h0000_0000;
        1:       base = 32'hFFFF_FFFF;
        default: base = $urandom();
      endcase
      case ($urandom_range(5))
        0:       pitch_bits = 32'd1;
        1:       pitch_bits = 32'd8192;
        2:       pitch_bits = $urandom();
        default: pitch_bits = $urandom_range(8192, 1);
      endcase
      set_regs(base, pitch_bits, $urandom(), bit'($urandom_range(1)));
      if (p == HOLD_PHASE) hold_req <= hold_req + 1;
      tx_steady = (p == STEADY_PHASE);
      rx_steady <= (p == STEADY_PHASE);
      for (int i = 0; i < PHASE_ITEMS; i++) send_glyph(rand_glyph());
    end

    // wait out the remaining rows and watch for stray ones
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
